// ===== sv/sbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbeq_pkg: shared types and constants for the stereo biquad equalizer
// Number formats, command codes and the lane/merge control struct.
// ----------------------------------------------------------------------------
package sbeq_pkg;

  localparam int BANDS = 10;
  localparam int NCOEF = 5;
  localparam int COEF_W = 32;
  localparam int HIST_W = 32;
  localparam int CFRAC = COEF_W - 4;
  localparam int HFRAC = 8;
  localparam int BAND_W = 4;
  localparam int CSEL_W = 3;
  localparam int PROD_W = COEF_W + HIST_W;
  localparam int ACC_W = PROD_W + 3;
  localparam int CIDX_W = $clog2(BANDS * NCOEF);
  // one history row per band: x1 x2 y1 y2 for both channels
  localparam int HIDX_W = $clog2(BANDS);
  localparam int HROW_W = 8 * HIST_W;

  // Command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  // Coefficient selects
  localparam logic [CSEL_W-1:0] SEL_B0 = 3'd0;
  localparam logic [CSEL_W-1:0] SEL_B1 = 3'd1;
  localparam logic [CSEL_W-1:0] SEL_B2 = 3'd2;
  localparam logic [CSEL_W-1:0] SEL_A1 = 3'd3;
  localparam logic [CSEL_W-1:0] SEL_A2 = 3'd4;
  // last MAC phase of a band: accumulate a2, no coefficient read
  localparam logic [CSEL_W-1:0] PH_LAST = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAC,
    ST_WB,
    ST_OUT
  } state_t;

  // Step control handed from the sequencer to both lanes
  typedef struct packed {
    logic                  start;   // load new lane input
    logic                  mac;     // accumulate one term
    logic [CSEL_W-1:0]     term;    // which term 0..4
    logic                  wb;      // round, write back, next band
  } lane_ctl_t;

  localparam logic signed [HIST_W-1:0] HMAX = {1'b0, {(HIST_W-1){1'b1}}};
  localparam logic signed [HIST_W-1:0] HMIN = {1'b1, {(HIST_W-1){1'b0}}};
  localparam logic signed [HIST_W-1:0] OUT_LIM = HIST_W'(32767 * 256);

  // Round to HFRAC fraction bits and saturate to a history word
  function automatic logic signed [HIST_W-1:0] round_sat(logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-CFRAC-1:0] q;
    t = s + (ACC_W'(1) <<< (CFRAC - 1));
    q = t[ACC_W-1:CFRAC];
    if (q > $signed((ACC_W-CFRAC)'(HMAX))) return HMAX;
    if (q < $signed({{(ACC_W-CFRAC-HIST_W){1'b1}}, HMIN})) return HMIN;
    return q[HIST_W-1:0];
  endfunction

  // Clamp to +/-32767 sample units and truncate toward zero
  function automatic logic signed [15:0] finish(logic signed [HIST_W-1:0] y);
    logic signed [HIST_W-1:0] c;
    logic [HIST_W-1:0] m;
    c = y;
    if (y > OUT_LIM) c = OUT_LIM;
    if (y < -OUT_LIM) c = -OUT_LIM;
    if (c[HIST_W-1]) begin
      m = HIST_W'(-c) >> HFRAC;
      return -$signed(m[15:0]);
    end
    m = HIST_W'(c) >> HFRAC;
    return m[15:0];
  endfunction

endpackage

// ===== sv/sbeq_ram.sv =====
// ----------------------------------------------------------------------------
// sbeq_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sbeq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read the addressed word
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== sv/sbeq_lane.sv =====
// ----------------------------------------------------------------------------
// sbeq_lane: one channel's biquad datapath
// Multiplies coefficients by history, accumulates, rounds and saturates.
// ----------------------------------------------------------------------------
module sbeq_lane (
  input  logic                                clk,
  input  sbeq_pkg::lane_ctl_t                 ctl,
  input  logic signed [15:0]                  sample,
  input  logic signed [sbeq_pkg::COEF_W-1:0]  coef,
  input  logic signed [sbeq_pkg::HIST_W-1:0]  hist,
  output logic signed [sbeq_pkg::HIST_W-1:0]  x_cur,
  output logic signed [sbeq_pkg::HIST_W-1:0]  y_new
);
  import sbeq_pkg::*;

  logic signed [HIST_W-1:0] x_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod;
  logic signed [HIST_W-1:0] opnd;

  // term 0 multiplies the section input, others the history word
  assign opnd = (ctl.term == SEL_B0) ? x_r : hist;
  assign prod = coef * opnd;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.mac) begin
      if (ctl.term == SEL_A1 || ctl.term == SEL_A2) acc_nxt = acc_r - ACC_W'(prod);
      else acc_nxt = acc_r + ACC_W'(prod);
    end
    if (ctl.wb) acc_nxt = '0;
  end

  assign y_new = round_sat(acc_r);
  assign x_cur = x_r;

  // advance section input: sample at start, section output at write back
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r   <= HIST_W'(sample) <<< HFRAC;
      acc_r <= '0;
    end else begin
      if (ctl.wb) x_r <= y_new;
      acc_r <= acc_nxt;
    end
  end
endmodule

// ===== sv/stereo_cascaded_biquad_equalizer.sv =====
// ----------------------------------------------------------------------------
// stereo_cascaded_biquad_equalizer: ten-band stereo DF-I biquad cascade
// Two lanes share one sequencer, the coefficient store and the history store.
//
//   channel | ports                              | direction
//   in      | in_valid/in_ready, command..last   | request in
//   out     | out_valid/out_ready, *_out         | result out
//
// A frame steps through ST_MAC and ST_WB for each band in turn, then ST_OUT;
// no new request is taken until it is done, and the result is registered.
// Per band: five coefficient reads on the single RAM port with one MAC per
// lane each, a phase to drain the last MAC, then a history write-back.
// After reset a clearing pass over all BANDS*NCOEF = 50 coefficient words
// loads pass-through coefficients and zeros the history; no request is
// taken then. A finished frame waits until the output register is free;
// requests are taken again once it has moved there.
// ----------------------------------------------------------------------------
module stereo_cascaded_biquad_equalizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_command,
  input  logic signed [15:0]                 in_right_in,
  input  logic signed [15:0]                 in_left_in,
  input  logic [sbeq_pkg::BAND_W-1:0]        in_band_select,
  input  logic [sbeq_pkg::CSEL_W-1:0]        in_coef_select,
  input  logic signed [31:0]                 in_coef_value,
  input  logic                               in_frame_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [15:0]                 out_right_out,
  output logic signed [15:0]                 out_left_out,
  output logic                               out_frame_last_out
);
  import sbeq_pkg::*;

  state_t state_r, state_nxt;
  logic [CIDX_W-1:0] cnt_r, cnt_nxt;          // clear index
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [CSEL_W-1:0] ph_r, ph_nxt;            // MAC phase, coefficient slot in clear
  logic last_r, olast_r, out_valid_r, ld_out;
  logic signed [15:0] ro_r, lo_r;
  lane_ctl_t ctl;

  logic cwe, hwe;
  logic [CIDX_W-1:0] caddr;
  logic [HIDX_W-1:0] haddr;
  logic [COEF_W-1:0] cwdata, crdata;
  logic [HROW_W-1:0] hwdata, hrdata;
  logic signed [HIST_W-1:0] rx1, rx2, ry1, ry2, lx1, lx2, ly1, ly2;
  logic signed [HIST_W-1:0] rx, lx, ry, ly, rhist, lhist;
  logic accept, coef_ok;

  assign accept  = in_valid && in_ready;
  assign coef_ok = (32'(in_band_select) < BANDS) && (32'(in_coef_select) < NCOEF);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; band_nxt = band_r; ph_nxt = ph_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        ph_nxt = (ph_r == SEL_A2) ? SEL_B0 : ph_r + 1'b1;
        if (32'(cnt_r) == BANDS * NCOEF - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_command == CMD_FRAME) begin
          state_nxt = ST_MAC; band_nxt = '0; ph_nxt = '0;
        end
      end
      ST_MAC: begin
        ph_nxt = ph_r + 1'b1;
        if (ph_r == PH_LAST) state_nxt = ST_WB;
      end
      ST_WB: begin
        band_nxt = band_r + 1'b1; ph_nxt = '0;
        if (32'(band_r) == BANDS - 1) state_nxt = ST_OUT;
        else state_nxt = ST_MAC;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0; cwe = 1'b0; hwe = 1'b0; ld_out = 1'b0;
    caddr = '0; haddr = '0; cwdata = '0; hwdata = '0;
    ctl = '0;
    case (state_r)
      ST_CLEAR: begin
        cwe = 1'b1; caddr = cnt_r;
        cwdata = (ph_r == SEL_B0) ? (COEF_W'(1) << CFRAC) : '0;
        haddr = HIDX_W'(cnt_r);
        hwe = (32'(cnt_r) < BANDS);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.start = accept && in_command == CMD_FRAME;
        if (accept && in_command == CMD_COEF && coef_ok) begin
          cwe = 1'b1;
          caddr = CIDX_W'(32'(in_band_select) * NCOEF + 32'(in_coef_select));
          cwdata = COEF_W'(in_coef_value);
        end
      end
      ST_MAC: begin
        // read coefficient of this phase, accumulate the one read last cycle
        haddr = HIDX_W'(band_r);
        caddr = CIDX_W'(32'(band_r) * NCOEF + ((ph_r == PH_LAST) ? 0 : 32'(ph_r)));
        if (ph_r != '0) begin
          ctl.mac = 1'b1; ctl.term = ph_r - 1'b1;
        end
      end
      ST_WB: begin
        // shift the band's history and store the new section output
        ctl.wb = 1'b1; hwe = 1'b1; haddr = HIDX_W'(band_r);
        hwdata = {rx, rx1, ry, ry1, lx, lx1, ly, ly1};
      end
      ST_OUT: ld_out = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // history row of the current band, stable from the second MAC phase on
  assign {rx1, rx2, ry1, ry2, lx1, lx2, ly1, ly2} = hrdata;

  always_comb begin
    case (ctl.term)
      SEL_B1: begin rhist = rx1; lhist = lx1; end
      SEL_B2: begin rhist = rx2; lhist = lx2; end
      SEL_A1: begin rhist = ry1; lhist = ly1; end
      SEL_A2: begin rhist = ry2; lhist = ly2; end
      default: begin rhist = '0; lhist = '0; end
    endcase
  end

  sbeq_ram #(.WIDTH(COEF_W), .DEPTH(BANDS * NCOEF)) u_coef (
    .clk(clk), .we(cwe), .addr(caddr), .wdata(cwdata), .rdata(crdata));

  sbeq_ram #(.WIDTH(HROW_W), .DEPTH(BANDS)) u_hist (
    .clk(clk), .we(hwe), .addr(haddr), .wdata(hwdata), .rdata(hrdata));

  sbeq_lane u_right (.clk(clk), .ctl(ctl), .sample(in_right_in), .coef(crdata),
    .hist(rhist), .x_cur(rx), .y_new(ry));
  sbeq_lane u_left (.clk(clk), .ctl(ctl), .sample(in_left_in), .coef(crdata),
    .hist(lhist), .x_cur(lx), .y_new(ly));

  // merge both lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR; cnt_r <= '0; band_r <= '0; ph_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; band_r <= band_nxt; ph_r <= ph_nxt;
      if (ld_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
    if (ctl.start) last_r <= in_frame_last;
    if (ld_out) begin
      ro_r <= finish(rx); lo_r <= finish(lx); olast_r <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_right_out = ro_r;
  assign out_left_out = lo_r;
  assign out_frame_last_out = olast_r;

  // no request accepted during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !in_ready) else $error("request taken during clear");
  // a waiting result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_right_out))
    else $error("result lost");
  // lanes only accumulate in the MAC state
  assert property (@(posedge clk) disable iff (!rst_n)
    ctl.mac |-> state_r == ST_MAC) else $error("stray accumulate");
endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the stereo cascaded biquad equalizer
// Drives frame and coefficient-write requests, mirrors the ten-band
// direct-form-I cascade in a bit-exact predictor and checks every result
// in order, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import sbeq_pkg::*;

  localparam int N_RANDOM = 1425;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;
  localparam logic signed [79:0] SAMPLE_LIM = 80'sd8388352;

  typedef struct {
    logic                  cmd;
    logic signed [15:0]    right;
    logic signed [15:0]    left;
    logic [BAND_W-1:0]     band;
    logic [CSEL_W-1:0]     sel;
    logic signed [31:0]    value;
    logic                  last;
    bit                    typed;
    logic signed [15:0]    exp_right;
    logic signed [15:0]    exp_left;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] right;
    logic signed [15:0] left;
    logic               last;
  } frame_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = CMD_FRAME;
  logic signed [15:0] in_right_in = '0;
  logic signed [15:0] in_left_in = '0;
  logic [BAND_W-1:0] in_band_select = '0;
  logic [CSEL_W-1:0] in_coef_select = '0;
  logic signed [31:0] in_coef_value = '0;
  logic in_frame_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_right_out;
  logic signed [15:0] out_left_out;
  logic out_frame_last_out;

  // Predictor state: coefficients per band, x1 x2 y1 y2 per band and channel
  logic signed [31:0] coef_mem [BANDS*NCOEF];
  logic signed [31:0] hist_mem [2][BANDS*4];
  frame_out_t expected_frames[$];
  stim_row_t table_rows[$];
  int errors = 0;
  int cycles = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;

  stereo_cascaded_biquad_equalizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_right_in(in_right_in), .in_left_in(in_left_in),
    .in_band_select(in_band_select), .in_coef_select(in_coef_select),
    .in_coef_value(in_coef_value), .in_frame_last(in_frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_right_out(out_right_out), .out_left_out(out_left_out),
    .out_frame_last_out(out_frame_last_out)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  // One biquad section on one channel, exact sum then round and saturate
  function automatic logic signed [31:0] biquad_section(int b, int ch,
                                                       logic signed [31:0] x);
    logic signed [79:0] acc;
    logic signed [79:0] q;
    logic signed [31:0] y;
    acc = 80'(coef_mem[b*NCOEF]) * 80'(x)
        + 80'(coef_mem[b*NCOEF+1]) * 80'(hist_mem[ch][b*4])
        + 80'(coef_mem[b*NCOEF+2]) * 80'(hist_mem[ch][b*4+1])
        - 80'(coef_mem[b*NCOEF+3]) * 80'(hist_mem[ch][b*4+2])
        - 80'(coef_mem[b*NCOEF+4]) * 80'(hist_mem[ch][b*4+3]);
    q = (acc + (80'sd1 <<< (CFRAC - 1))) >>> CFRAC;
    if (q > 80'sd2147483647) y = 32'sh7fff_ffff;
    else if (q < -80'sd2147483648) y = 32'sh8000_0000;
    else y = q[31:0];
    hist_mem[ch][b*4+1] = hist_mem[ch][b*4];
    hist_mem[ch][b*4] = x;
    hist_mem[ch][b*4+3] = hist_mem[ch][b*4+2];
    hist_mem[ch][b*4+2] = y;
    return y;
  endfunction

  // Clamp to the sample range and truncate toward zero
  function automatic logic signed [15:0] to_sample(logic signed [31:0] y);
    logic signed [79:0] v;
    logic signed [79:0] s;
    v = 80'(y);
    if (v > SAMPLE_LIM) v = SAMPLE_LIM;
    if (v < -SAMPLE_LIM) v = -SAMPLE_LIM;
    s = (v < 0) ? -((-v) >>> HFRAC) : (v >>> HFRAC);
    return s[15:0];
  endfunction

  // Update the predicted state for one request; return 1 if a frame results
  function automatic bit equalize_request(stim_row_t rq, output frame_out_t fo);
    logic signed [31:0] r;
    logic signed [31:0] l;
    if (rq.cmd == CMD_COEF) begin
      if (rq.band < BANDS && rq.sel < NCOEF) coef_mem[rq.band*NCOEF + rq.sel] = rq.value;
      return 0;
    end
    r = 32'(rq.right) <<< HFRAC;
    l = 32'(rq.left) <<< HFRAC;
    for (int b = 0; b < BANDS; b++) begin
      r = biquad_section(b, 0, r);
      l = biquad_section(b, 1, l);
    end
    fo.right = to_sample(r);
    fo.left = to_sample(l);
    fo.last = rq.last;
    return 1;
  endfunction

  function automatic stim_row_t frame_row(int r, int l, bit last, bit typed,
                                          int er, int el);
    stim_row_t t;
    t = '{cmd: CMD_FRAME, right: 16'(r), left: 16'(l), band: '0, sel: '0,
          value: '0, last: last, typed: typed, exp_right: 16'(er), exp_left: 16'(el)};
    return t;
  endfunction

  function automatic stim_row_t coef_row(int band, int sel, logic signed [31:0] v);
    stim_row_t t;
    t = '{cmd: CMD_COEF, right: '0, left: '0, band: 4'(band), sel: 3'(sel),
          value: v, last: 1'b0, typed: 0, exp_right: '0, exp_left: '0};
    return t;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t t;
    int pick;
    pick = $urandom_range(0, 99);
    t = frame_row(0, 0, 1'b0, 0, 0, 0);
    if (pick < 22) begin
      t = coef_row($urandom_range(0, 99) < 90 ? $urandom_range(0, BANDS-1)
                                              : $urandom_range(0, 15),
                   $urandom_range(0, 99) < 90 ? $urandom_range(0, NCOEF-1)
                                              : $urandom_range(0, 7), '0);
      case ($urandom_range(0, 9))
        0: t.value = $urandom;
        1: t.value = Q_ONE;
        2: t.value = '0;
        default: begin
          // keep most filters near unity so the cascade stays in range
          if (t.sel <= SEL_B2) t.value = $signed($urandom_range(0, 1 << 29)) - Q_ONE;
          else t.value = $signed($urandom_range(0, 1 << 27)) - (Q_ONE >>> 2);
        end
      endcase
    end else begin
      t.right = 16'($urandom);
      t.left = 16'($urandom);
      if ($urandom_range(0, 3) == 0) begin
        t.right = $signed(16'($urandom_range(0, 511))) - 16'sd256;
        t.left = $signed(16'($urandom_range(0, 511))) - 16'sd256;
      end
      t.last = 1'($urandom_range(0, 1));
    end
    return t;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(stim_row_t rq);
    frame_out_t fo;
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= rq.cmd;
    in_right_in <= rq.right;
    in_left_in <= rq.left;
    in_band_select <= rq.band;
    in_coef_select <= rq.sel;
    in_coef_value <= rq.value;
    in_frame_last <= rq.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (equalize_request(rq, fo)) begin
      if (rq.typed) begin
        fo.right = rq.exp_right;
        fo.left = rq.exp_left;
      end
      expected_frames.push_back(fo);
    end
  endtask

  // Drive receiver stalls and check each accepted result
  always @(posedge clk) begin
    frame_out_t want;
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result", out_right_out, 0);
      end else begin
        want = expected_frames.pop_front();
        if (out_right_out !== want.right) report_mismatch("right_out", out_right_out, want.right);
        if (out_left_out !== want.left) report_mismatch("left_out", out_left_out, want.left);
        if (out_frame_last_out !== want.last)
          report_mismatch("frame_last_out", out_frame_last_out, want.last);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("stereo_cascaded_biquad_equalizer test failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rq;
    for (int i = 0; i < BANDS*NCOEF; i++) coef_mem[i] = (i % NCOEF == 0) ? Q_ONE : '0;
    for (int i = 0; i < BANDS*4; i++) begin
      hist_mem[0][i] = '0;
      hist_mem[1][i] = '0;
    end

    // Directed: pass-through after reset, extremes, ignored writes, gain
    table_rows.push_back(frame_row(0, 0, 1'b0, 1, 0, 0));
    table_rows.push_back(frame_row(32767, -32768, 1'b1, 1, 32767, -32767));
    table_rows.push_back(frame_row(-1, 1, 1'b0, 1, -1, 1));
    table_rows.push_back(frame_row(12345, -12345, 1'b1, 1, 12345, -12345));
    table_rows.push_back(coef_row(15, SEL_B0, '0));
    table_rows.push_back(coef_row(0, 7, '0));
    table_rows.push_back(coef_row(BANDS, SEL_B0, '0));
    table_rows.push_back(coef_row(0, NCOEF, '0));
    table_rows.push_back(frame_row(100, -100, 1'b0, 1, 100, -100));
    table_rows.push_back(coef_row(0, SEL_B0, Q_ONE <<< 1));
    table_rows.push_back(frame_row(20000, -20000, 1'b0, 1, 32767, -32767));
    table_rows.push_back(frame_row(1000, -1000, 1'b1, 1, 2000, -2000));
    table_rows.push_back(coef_row(BANDS-1, SEL_B1, 32'sh7fff_ffff));
    table_rows.push_back(coef_row(BANDS-1, SEL_B2, 32'sh8000_0000));
    table_rows.push_back(coef_row(5, SEL_A1, -Q_ONE));
    table_rows.push_back(coef_row(5, SEL_A2, 32'sh0c00_0000));
    table_rows.push_back(frame_row(32767, 32767, 1'b0, 0, 0, 0));
    table_rows.push_back(frame_row(-32768, -32768, 1'b1, 0, 0, 0));
    table_rows.push_back(frame_row(0, 0, 1'b0, 0, 0, 0));
    table_rows.push_back(frame_row(-7, 5, 1'b0, 0, 0, 0));
    table_rows.push_back(coef_row(BANDS-1, SEL_B1, '0));
    table_rows.push_back(coef_row(BANDS-1, SEL_B2, '0));
    table_rows.push_back(coef_row(5, SEL_A1, 32'sh8000_0000));
    table_rows.push_back(frame_row(4096, -4096, 1'b1, 0, 0, 0));
    table_rows.push_back(frame_row(-300, 300, 1'b0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send_request(table_rows[i]);

    // Random requests over four idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 84; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 84; end
        default: begin sender_idle_pct = 30; stall_pct = 30; end
      endcase
      rq = random_row();
      send_request(rq);
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("stereo_cascaded_biquad_equalizer test passed");
    end else begin
      $display("stereo_cascaded_biquad_equalizer test failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/sbeq_pkg.sv
sv/sbeq_ram.sv
sv/sbeq_lane.sv
sv/stereo_cascaded_biquad_equalizer.sv
bench/tb.sv
